// File: rtl/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants of the i2c bit level master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_PHASE_TICKS = 2'd0;
    localparam logic [1:0] CFG_POLL_TICKS  = 2'd1;
    localparam logic [1:0] CFG_ACK_LIMIT   = 2'd2;

    // reset values of the configuration registers
    localparam logic [15:0] PHASE_TICKS_RST = 16'd5;
    localparam logic [15:0] POLL_TICKS_RST  = 16'd1;
    localparam logic [7:0]  ACK_LIMIT_RST   = 8'd10;

    // bits per byte on the bus
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // command codes
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_WACK  = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    // sequencer steps
    typedef enum logic [4:0] {
        S_IDLE   = 5'd0,
        S_STLOW  = 5'd1,
        S_STSCL  = 5'd2,
        S_SPHIGH = 5'd3,
        S_SPEND  = 5'd4,
        S_WRRISE = 5'd5,
        S_WRFALL = 5'd6,
        S_WRNEXT = 5'd7,
        S_WARISE = 5'd8,
        S_WAPOLL = 5'd9,
        S_RDRISE = 5'd10,
        S_RDNEXT = 5'd11,
        S_ARISE  = 5'd12,
        S_AFALL  = 5'd13
    } t_step;

    // configuration registers
    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [15:0] poll_ticks;
        logic [7:0]  ack_poll_limit;
    } t_cfg;

    // one input tick
    typedef struct packed {
        logic       sda_sample;
        logic       send_ack;
        logic [7:0] write_byte;
        logic [2:0] opcode;
        logic       cmd_valid;
    } t_cmd;

    // one result tick
    typedef struct packed {
        logic       ack_error;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } t_res;

    // a zero delay counts as one tick
    function automatic logic [15:0] delay_of(input logic [15:0] d);
        delay_of = (d == 16'd0) ? 16'd1 : d;
    endfunction

endpackage

// File: rtl/i2cbm_core.sv
// ----------------------------------------------------------------------------
// i2cbm_core
// Bus sequencer: holds the bit level state and advances it by one tick.
// ----------------------------------------------------------------------------
module i2cbm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  i2cbm_pkg::t_cmd   i_cmd,
    input  i2cbm_pkg::t_cfg   i_cfg,
    output i2cbm_pkg::t_res   o_res
);

    i2cbm_pkg::t_step r_step,   n_step;
    i2cbm_pkg::t_op   r_op,     n_op;
    logic [15:0]      r_timer,  n_timer;
    logic [3:0]       r_bits,   n_bits;
    logic [7:0]       r_shift,  n_shift;
    logic [7:0]       r_polls,  n_polls;
    logic             r_ack,    n_ack;
    logic             r_scl,    n_scl;
    logic             r_sda,    n_sda;
    logic             r_drv,    n_drv;
    logic [7:0]       r_rd,     n_rd;
    logic             r_err,    n_err;
    logic             n_done;

    // next state for one tick
    always_comb begin
        logic [3:0]  bits_inc;
        logic [7:0]  shift_up;
        logic [15:0] phase_d;
        logic [15:0] poll_d;

        bits_inc = r_bits + 4'd1;
        shift_up = {r_shift[6:0], 1'b0};
        phase_d  = i2cbm_pkg::delay_of(i_cfg.phase_ticks);
        poll_d   = i2cbm_pkg::delay_of(i_cfg.poll_ticks);

        n_step  = r_step;
        n_op    = r_op;
        n_timer = r_timer;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_polls = r_polls;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        n_rd    = r_rd;
        n_err   = r_err;
        n_done  = 1'b0;

        if (r_step == i2cbm_pkg::S_IDLE) begin
            // take a command only while idle
            if (i_cmd.cmd_valid && (i_cmd.opcode <= i2cbm_pkg::OP_READ)) begin
                n_op    = i2cbm_pkg::t_op'(i_cmd.opcode);
                n_bits  = 4'd0;
                n_polls = 8'd0;
                n_timer = phase_d;
                case (i_cmd.opcode)
                    i2cbm_pkg::OP_START: begin
                        n_drv  = 1'b1; n_scl = 1'b1; n_sda = 1'b1;
                        n_step = i2cbm_pkg::S_STLOW;
                    end
                    i2cbm_pkg::OP_STOP: begin
                        n_drv  = 1'b1; n_scl = 1'b1; n_sda = 1'b0;
                        n_step = i2cbm_pkg::S_SPHIGH;
                    end
                    i2cbm_pkg::OP_WRITE: begin
                        n_drv   = 1'b1; n_scl = 1'b0;
                        n_shift = i_cmd.write_byte;
                        n_sda   = i_cmd.write_byte[7];
                        n_step  = i2cbm_pkg::S_WRRISE;
                    end
                    i2cbm_pkg::OP_WACK: begin
                        n_drv  = 1'b0; n_sda = 1'b1;
                        n_step = i2cbm_pkg::S_WARISE;
                    end
                    default: begin
                        n_ack   = i_cmd.send_ack;
                        n_shift = 8'd0;
                        n_drv   = 1'b0; n_scl = 1'b0;
                        n_step  = i2cbm_pkg::S_RDRISE;
                    end
                endcase
            end
        end else if (r_timer > 16'd1) begin
            // count down the current delay
            n_timer = r_timer - 16'd1;
        end else begin
            // delay over: next bus action
            n_timer = 16'd0;
            case (r_step)
                i2cbm_pkg::S_STLOW: begin
                    n_sda = 1'b0; n_timer = phase_d; n_step = i2cbm_pkg::S_STSCL;
                end
                i2cbm_pkg::S_STSCL: begin
                    n_scl = 1'b0; n_step = i2cbm_pkg::S_IDLE; n_done = 1'b1;
                end
                i2cbm_pkg::S_SPHIGH: begin
                    n_sda = 1'b1; n_timer = phase_d; n_step = i2cbm_pkg::S_SPEND;
                end
                i2cbm_pkg::S_SPEND: begin
                    if (r_op == i2cbm_pkg::OP_WACK) begin
                        n_err = 1'b1;
                    end
                    n_step = i2cbm_pkg::S_IDLE; n_done = 1'b1;
                end
                i2cbm_pkg::S_WRRISE: begin
                    n_scl = 1'b1; n_timer = phase_d; n_step = i2cbm_pkg::S_WRFALL;
                end
                i2cbm_pkg::S_WRFALL: begin
                    n_scl = 1'b0; n_timer = phase_d; n_step = i2cbm_pkg::S_WRNEXT;
                end
                i2cbm_pkg::S_WRNEXT: begin
                    n_shift = shift_up;
                    n_bits  = bits_inc;
                    if (bits_inc >= i2cbm_pkg::BYTE_BITS) begin
                        n_step = i2cbm_pkg::S_IDLE; n_done = 1'b1;
                    end else begin
                        n_sda   = shift_up[7];
                        n_timer = phase_d;
                        n_step  = i2cbm_pkg::S_WRRISE;
                    end
                end
                i2cbm_pkg::S_WARISE: begin
                    n_scl = 1'b1; n_timer = phase_d; n_step = i2cbm_pkg::S_WAPOLL;
                end
                i2cbm_pkg::S_WAPOLL: begin
                    if (!i_cmd.sda_sample) begin
                        n_scl = 1'b0; n_err = 1'b0;
                        n_step = i2cbm_pkg::S_IDLE; n_done = 1'b1;
                    end else if (r_polls >= i_cfg.ack_poll_limit) begin
                        // timeout: run a stop
                        n_drv   = 1'b1; n_scl = 1'b1; n_sda = 1'b0;
                        n_timer = phase_d;
                        n_step  = i2cbm_pkg::S_SPHIGH;
                    end else begin
                        n_polls = r_polls + 8'd1;
                        n_timer = poll_d;
                        n_step  = i2cbm_pkg::S_WAPOLL;
                    end
                end
                i2cbm_pkg::S_RDRISE: begin
                    n_scl   = 1'b1;
                    n_shift = {r_shift[6:0], i_cmd.sda_sample};
                    n_timer = phase_d;
                    n_step  = i2cbm_pkg::S_RDNEXT;
                end
                i2cbm_pkg::S_RDNEXT: begin
                    n_bits  = bits_inc;
                    n_scl   = 1'b0;
                    n_timer = phase_d;
                    if (bits_inc >= i2cbm_pkg::BYTE_BITS) begin
                        n_rd   = r_shift;
                        n_drv  = 1'b1;
                        n_sda  = !r_ack;
                        n_step = i2cbm_pkg::S_ARISE;
                    end else begin
                        n_step = i2cbm_pkg::S_RDRISE;
                    end
                end
                i2cbm_pkg::S_ARISE: begin
                    n_scl = 1'b1; n_timer = phase_d; n_step = i2cbm_pkg::S_AFALL;
                end
                i2cbm_pkg::S_AFALL: begin
                    n_scl = 1'b0; n_step = i2cbm_pkg::S_IDLE; n_done = 1'b1;
                end
                default: begin
                    n_step = i2cbm_pkg::S_IDLE; n_done = 1'b1;
                end
            endcase
        end
    end

    // sequencer state, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= i2cbm_pkg::S_IDLE;
            r_op    <= i2cbm_pkg::OP_START;
            r_timer <= 16'd0;
            r_bits  <= 4'd0;
            r_shift <= 8'd0;
            r_polls <= 8'd0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drv   <= 1'b1;
            r_rd    <= 8'd0;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_step  <= n_step;
            r_op    <= n_op;
            r_timer <= n_timer;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_polls <= n_polls;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drv   <= n_drv;
            r_rd    <= n_rd;
            r_err   <= n_err;
        end
    end

    // result of this tick, seen after the update
    always_comb begin
        o_res.scl_level = n_scl;
        o_res.sda_level = n_sda;
        o_res.sda_drive = n_drv;
        o_res.busy_res  = (n_step != i2cbm_pkg::S_IDLE);
        o_res.done_res  = n_done;
        o_res.read_byte = n_rd;
        o_res.ack_error = n_err;
    end

endmodule

// File: rtl/i2c_bit_level_master.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Tick driven i2c master: start, stop, write byte, wait ack, read byte.
// ----------------------------------------------------------------------------
// Each beat on the slave stream is one bus tick; it may carry a command,
// taken only while the sequencer is idle, and always carries the sampled
// SDA level. Every accepted beat yields exactly one result beat on the
// master stream with the SCL/SDA levels, SDA direction, busy and done
// flags, the last read byte and the acknowledge error flag after that tick.
// A result beat is registered, valid in the cycle after its input beat; one beat
// is taken every cycle unless the receiver stalls, step and result register sharing it.
// Bus timing is counted in beats: each phase lasts phase_ticks beats and
// acknowledge polls are poll_ticks beats apart (zero counts as one).
// The user writes configuration through the plain write port only while idle;
// the block does not enforce this. A synchronous active-low reset puts the
// sequencer idle with SCL high and SDA driven high, and loads the register
// defaults (5, 1, 10). When the receiver stalls, the result register holds
// its beat; the slave side stops accepting until it is taken, so no tick is lost.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // cmd_valid, opcode[2:0], write_byte[7:0], send_ack, sda_sample, pad
    input  logic [15:0] i_s_tdata,
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // scl_level, sda_level, sda_drive, busy_res, done_res, read_byte[7:0],
    // ack_error, pad
    output logic [15:0] o_m_tdata,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    i2cbm_pkg::t_cfg r_cfg;
    i2cbm_pkg::t_cmd w_cmd;
    i2cbm_pkg::t_res w_res;
    i2cbm_pkg::t_res r_res;
    logic            r_out_vld;
    logic            w_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks    <= i2cbm_pkg::PHASE_TICKS_RST;
            r_cfg.poll_ticks     <= i2cbm_pkg::POLL_TICKS_RST;
            r_cfg.ack_poll_limit <= i2cbm_pkg::ACK_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            priority case (i_cfg_addr)
                i2cbm_pkg::CFG_PHASE_TICKS: r_cfg.phase_ticks    <= i_cfg_wdata;
                i2cbm_pkg::CFG_POLL_TICKS:  r_cfg.poll_ticks     <= i_cfg_wdata;
                i2cbm_pkg::CFG_ACK_LIMIT:   r_cfg.ack_poll_limit <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // input beat unpacking
    assign w_cmd = i2cbm_pkg::t_cmd'(i_s_tdata[13:0]);

    // accept whenever the result register is free or draining
    assign o_s_tready = !r_out_vld || i_m_tready;
    assign w_take     = i_s_tvalid && o_s_tready;

    i2cbm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_take),
        .i_cmd   (w_cmd),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_take) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= w_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_res};

endmodule

// File: tb/i2c_bit_level_master_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_test
// Self-checking bench for the tick driven i2c bit level master.
// ----------------------------------------------------------------------------
// Every slave beat is one bus tick. A tick-accurate predictor of the
// sequencer runs on each accepted beat and queues the expected line levels
// and flags; a monitor compares every master beat with the oldest entry.
// Directed tests hit every command, bad opcodes, commands offered while
// busy and on the done tick, acknowledge timeouts, zero and large delays.
// Random phases then run mostly well formed transactions (start, write,
// wait ack, reads, stop) with noise, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_test;

    localparam int unsigned CYCLE_LIMIT = 200_000;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_en   = 1'b0;
    logic [1:0]  cfg_addr = i2cbm_pkg::CFG_PHASE_TICKS;
    logic [15:0] cfg_data = 16'h0000;

    // traffic shaping, in percent
    int idle_pct  = 0;
    int stall_pct = 0;
    bit valid_up  = 1'b0;

    // run statistics
    int fail_cnt  = 0;
    int res_cnt   = 0;
    int cmd_cnt   = 0;
    int beat_cnt  = 0;
    int tmo_cnt   = 0;
    int cfg_cnt   = 0;
    int unsigned cyc_cnt = 0;

    // predictor copy of the registers and the sequencer
    logic [15:0]      cfg_phase;
    logic [15:0]      cfg_poll;
    logic [7:0]       cfg_limit;
    i2cbm_pkg::t_step bus_phase;
    logic [2:0]       op_held;
    logic [15:0]      tick_wait;
    logic [3:0]       bits_done;
    logic [7:0]       shreg;
    logic [7:0]       polls_failed;
    logic             ack_pick;
    logic             scl_q, sda_q, drv_q, done_q, err_hold;
    logic [7:0]       rd_hold;

    // expected bus view after each accepted tick
    i2cbm_pkg::t_res bus_view_q[$];

    // well formed transaction cursor for the random part
    int txn_pos = 0;

    i2c_bit_level_master u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_wr_en (cfg_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // load the next delay and step
    task automatic arm(input logic [15:0] d, input i2cbm_pkg::t_step nxt);
        tick_wait = (d == 16'd0) ? 16'd1 : d;
        bus_phase = nxt;
    endtask

    // command complete
    task automatic retire();
        bus_phase = i2cbm_pkg::S_IDLE;
        tick_wait = 16'd0;
        done_q    = 1'b1;
    endtask

    // advance the sequencer by one tick and queue the expected view
    task automatic predict_tick(input i2cbm_pkg::t_cmd c);
        i2cbm_pkg::t_res r;
        done_q = 1'b0;
        if (bus_phase == i2cbm_pkg::S_IDLE) begin
            if (c.cmd_valid && c.opcode <= i2cbm_pkg::OP_READ) begin
                op_held      = c.opcode;
                bits_done    = 4'd0;
                polls_failed = 8'd0;
                case (c.opcode)
                    i2cbm_pkg::OP_START: begin
                        drv_q = 1'b1; scl_q = 1'b1; sda_q = 1'b1;
                        arm(cfg_phase, i2cbm_pkg::S_STLOW);
                    end
                    i2cbm_pkg::OP_STOP: begin
                        drv_q = 1'b1; scl_q = 1'b1; sda_q = 1'b0;
                        arm(cfg_phase, i2cbm_pkg::S_SPHIGH);
                    end
                    i2cbm_pkg::OP_WRITE: begin
                        drv_q = 1'b1; scl_q = 1'b0;
                        shreg = c.write_byte;
                        sda_q = c.write_byte[7];
                        arm(cfg_phase, i2cbm_pkg::S_WRRISE);
                    end
                    i2cbm_pkg::OP_WACK: begin
                        drv_q = 1'b0; sda_q = 1'b1;
                        arm(cfg_phase, i2cbm_pkg::S_WARISE);
                    end
                    default: begin
                        ack_pick = c.send_ack;
                        shreg = 8'h00;
                        drv_q = 1'b0; scl_q = 1'b0;
                        arm(cfg_phase, i2cbm_pkg::S_RDRISE);
                    end
                endcase
            end
        end else if (tick_wait > 16'd1) begin
            tick_wait = tick_wait - 16'd1;
        end else begin
            tick_wait = 16'd0;
            case (bus_phase)
                i2cbm_pkg::S_STLOW: begin
                    sda_q = 1'b0;
                    arm(cfg_phase, i2cbm_pkg::S_STSCL);
                end
                i2cbm_pkg::S_STSCL: begin
                    scl_q = 1'b0;
                    retire();
                end
                i2cbm_pkg::S_SPHIGH: begin
                    sda_q = 1'b1;
                    arm(cfg_phase, i2cbm_pkg::S_SPEND);
                end
                i2cbm_pkg::S_SPEND: begin
                    if (op_held == i2cbm_pkg::OP_WACK) err_hold = 1'b1;
                    retire();
                end
                i2cbm_pkg::S_WRRISE: begin
                    scl_q = 1'b1;
                    arm(cfg_phase, i2cbm_pkg::S_WRFALL);
                end
                i2cbm_pkg::S_WRFALL: begin
                    scl_q = 1'b0;
                    arm(cfg_phase, i2cbm_pkg::S_WRNEXT);
                end
                i2cbm_pkg::S_WRNEXT: begin
                    shreg = {shreg[6:0], 1'b0};
                    bits_done = bits_done + 4'd1;
                    if (bits_done >= i2cbm_pkg::BYTE_BITS) begin
                        retire();
                    end else begin
                        sda_q = shreg[7];
                        arm(cfg_phase, i2cbm_pkg::S_WRRISE);
                    end
                end
                i2cbm_pkg::S_WARISE: begin
                    scl_q = 1'b1;
                    arm(cfg_phase, i2cbm_pkg::S_WAPOLL);
                end
                i2cbm_pkg::S_WAPOLL: begin
                    if (!c.sda_sample) begin
                        scl_q = 1'b0;
                        err_hold = 1'b0;
                        retire();
                    end else if (polls_failed >= cfg_limit) begin
                        // give up: stop condition, flagged at its end
                        drv_q = 1'b1; scl_q = 1'b1; sda_q = 1'b0;
                        arm(cfg_phase, i2cbm_pkg::S_SPHIGH);
                    end else begin
                        polls_failed = polls_failed + 8'd1;
                        arm(cfg_poll, i2cbm_pkg::S_WAPOLL);
                    end
                end
                i2cbm_pkg::S_RDRISE: begin
                    scl_q = 1'b1;
                    shreg = {shreg[6:0], c.sda_sample};
                    arm(cfg_phase, i2cbm_pkg::S_RDNEXT);
                end
                i2cbm_pkg::S_RDNEXT: begin
                    bits_done = bits_done + 4'd1;
                    scl_q = 1'b0;
                    if (bits_done >= i2cbm_pkg::BYTE_BITS) begin
                        rd_hold = shreg;
                        drv_q = 1'b1;
                        sda_q = ~ack_pick;
                        arm(cfg_phase, i2cbm_pkg::S_ARISE);
                    end else begin
                        arm(cfg_phase, i2cbm_pkg::S_RDRISE);
                    end
                end
                i2cbm_pkg::S_ARISE: begin
                    scl_q = 1'b1;
                    arm(cfg_phase, i2cbm_pkg::S_AFALL);
                end
                i2cbm_pkg::S_AFALL: begin
                    scl_q = 1'b0;
                    retire();
                end
                default: retire();
            endcase
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.sda_drive = drv_q;
        r.busy_res  = (bus_phase != i2cbm_pkg::S_IDLE);
        r.done_res  = done_q;
        r.read_byte = rd_hold;
        r.ack_error = err_hold;
        bus_view_q.push_back(r);
    endtask

    // drive one tick beat, wait for acceptance, maybe leave a gap
    task automatic send_beat(input i2cbm_pkg::t_cmd c);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, c};
        valid_up = 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_tick(c);
        beat_cnt++;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            valid_up = 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every queued result
    task automatic hold_until_drained();
        if (valid_up) begin
            s_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
        while (bus_view_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic sda_of(input int low_pct);
        return !($urandom_range(0, 99) < low_pct);
    endfunction

    // offer one command at idle, then tick until it is done;
    // busy ticks carry junk commands with the given probability
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] wb, input logic ack,
                           input int low_pct, input int noise_pct);
        i2cbm_pkg::t_cmd c;
        c.cmd_valid  = 1'b1;
        c.opcode     = op;
        c.write_byte = wb;
        c.send_ack   = ack;
        c.sda_sample = sda_of(low_pct);
        send_beat(c);
        if (op <= i2cbm_pkg::OP_READ) cmd_cnt++;
        while (bus_phase != i2cbm_pkg::S_IDLE) begin
            c.cmd_valid  = ($urandom_range(0, 99) < noise_pct);
            c.opcode     = 3'($urandom_range(0, 7));
            c.write_byte = 8'($urandom_range(0, 255));
            c.send_ack   = 1'($urandom_range(0, 1));
            c.sda_sample = sda_of(low_pct);
            send_beat(c);
        end
        if (op == i2cbm_pkg::OP_WACK && err_hold) tmo_cnt++;
    endtask

    // write all three registers, block idle and drained
    task automatic set_cfg(input logic [15:0] ph, input logic [15:0] po, input logic [7:0] lim);
        hold_until_drained();
        cfg_en   <= 1'b1;
        cfg_addr <= i2cbm_pkg::CFG_PHASE_TICKS;
        cfg_data <= ph;
        @(posedge i_clk);
        cfg_addr <= i2cbm_pkg::CFG_POLL_TICKS;
        cfg_data <= po;
        @(posedge i_clk);
        cfg_addr <= i2cbm_pkg::CFG_ACK_LIMIT;
        cfg_data <= {8'h00, lim};
        @(posedge i_clk);
        cfg_en   <= 1'b0;
        cfg_phase = ph;
        cfg_poll  = po;
        cfg_limit = lim;
        cfg_cnt++;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            fail_cnt++;
        end
    endtask

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        i2cbm_pkg::t_res want;
        i2cbm_pkg::t_res got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = i2cbm_pkg::t_res'(m_tdata[13:0]);
            if (bus_view_q.size() == 0) begin
                $error("result beat with nothing expected");
                fail_cnt++;
            end else begin
                want = bus_view_q.pop_front();
                check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
                check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
                check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
                check_field("busy_res",  8'(want.busy_res),  8'(got.busy_res));
                check_field("done_res",  8'(want.done_res),  8'(got.done_res));
                check_field("read_byte", want.read_byte, got.read_byte);
                check_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
                res_cnt++;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------------------------------------------------------- tests

    // one full transaction at reset settings
    task automatic test_defaults();
        run_cmd(i2cbm_pkg::OP_START, 8'h00, 1'b0, 50, 0);
        run_cmd(i2cbm_pkg::OP_WRITE, 8'hA5, 1'b0, 50, 0);
        run_cmd(i2cbm_pkg::OP_WACK,  8'h00, 1'b0, 100, 0);
        run_cmd(i2cbm_pkg::OP_READ,  8'h00, 1'b1, 50, 0);
        run_cmd(i2cbm_pkg::OP_STOP,  8'h00, 1'b0, 50, 0);
    endtask

    // opcodes 5 to 7 are ignored
    task automatic test_bad_opcodes();
        run_cmd(3'd5, 8'hFF, 1'b1, 0, 0);
        run_cmd(3'd6, 8'h00, 1'b0, 100, 0);
        run_cmd(3'd7, 8'hAA, 1'b1, 50, 0);
    endtask

    // commands offered on every busy tick, the done tick included
    task automatic test_busy_noise();
        run_cmd(i2cbm_pkg::OP_START, 8'h00, 1'b0, 50, 100);
        run_cmd(i2cbm_pkg::OP_READ,  8'h00, 1'b0, 50, 100);
    endtask

    // first no acknowledge comes: timeout stop with error flag; then one is acknowledged
    task automatic test_ack_timeout();
        run_cmd(i2cbm_pkg::OP_WACK, 8'h00, 1'b0, 0, 0);
        run_cmd(i2cbm_pkg::OP_WACK, 8'h00, 1'b0, 100, 0);
    endtask

    // zero delay registers act as one tick, zero poll limit
    task automatic test_zero_delays();
        set_cfg(16'd0, 16'd0, 8'd0);
        run_cmd(i2cbm_pkg::OP_START, 8'h00, 1'b0, 50, 0);
        run_cmd(i2cbm_pkg::OP_WRITE, 8'hA5, 1'b0, 50, 0);
        run_cmd(i2cbm_pkg::OP_WACK,  8'h00, 1'b0, 0, 0);
        run_cmd(i2cbm_pkg::OP_READ,  8'h00, 1'b0, 50, 0);
        run_cmd(i2cbm_pkg::OP_STOP,  8'h00, 1'b0, 50, 0);
    endtask

    // largest poll limit, long phase and long poll delays
    task automatic test_long_delays();
        set_cfg(16'd1, 16'd1, 8'hFF);
        run_cmd(i2cbm_pkg::OP_WACK, 8'h00, 1'b0, 0, 0);
        set_cfg(16'd40, 16'd1, 8'd0);
        run_cmd(i2cbm_pkg::OP_START, 8'h00, 1'b0, 50, 0);
        set_cfg(16'd2, 16'd100, 8'd1);
        run_cmd(i2cbm_pkg::OP_WACK, 8'h00, 1'b0, 0, 0);
    endtask

    // mostly well formed transactions, some stray commands and noise
    task automatic test_random(input int idle_p, input int stall_p, input int n_beats);
        int done_here;
        int first_beat;
        logic [2:0] op;
        int r;
        int low;
        idle_pct   = idle_p;
        stall_pct  = stall_p;
        done_here  = 0;
        first_beat = beat_cnt;
        while (beat_cnt - first_beat < n_beats) begin
            if (done_here % 6 == 0) begin
                set_cfg(16'(($urandom_range(0, 4) == 0) ? $urandom_range(5, 12)
                                                        : $urandom_range(1, 4)),
                        16'($urandom_range(1, 4)), 8'($urandom_range(0, 12)));
            end
            case (txn_pos)
                0: begin op = i2cbm_pkg::OP_START; txn_pos = 1; end
                1: begin op = i2cbm_pkg::OP_WRITE; txn_pos = 2; end
                2: begin op = i2cbm_pkg::OP_WACK;  txn_pos = 3; end
                default: begin
                    r = $urandom_range(0, 9);
                    if (r < 3) begin
                        op = i2cbm_pkg::OP_STOP; txn_pos = 0;
                    end else if (r < 6) begin
                        op = i2cbm_pkg::OP_WRITE; txn_pos = 2;
                    end else begin
                        op = i2cbm_pkg::OP_READ;
                    end
                end
            endcase
            if ($urandom_range(0, 99) < 15) op = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
                0: low = 0;
                1: low = 20;
                2: low = 60;
                default: low = 100;
            endcase
            if (op != i2cbm_pkg::OP_WACK) low = 50;
            run_cmd(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), low, 20);
            if (op <= i2cbm_pkg::OP_READ) done_here++;
            // occasional hold-off until the output side catches up
            if ($urandom_range(0, 99) < 2) hold_until_drained();
        end
    endtask

    initial begin
        cfg_phase    = i2cbm_pkg::PHASE_TICKS_RST;
        cfg_poll     = i2cbm_pkg::POLL_TICKS_RST;
        cfg_limit    = i2cbm_pkg::ACK_LIMIT_RST;
        bus_phase    = i2cbm_pkg::S_IDLE;
        op_held      = 3'd0;
        tick_wait    = 16'd0;
        bits_done    = 4'd0;
        shreg        = 8'h00;
        polls_failed = 8'h00;
        ack_pick     = 1'b0;
        scl_q        = 1'b1;
        sda_q        = 1'b1;
        drv_q        = 1'b1;
        done_q       = 1'b0;
        err_hold     = 1'b0;
        rd_hold      = 8'h00;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_bad_opcodes();
        test_ack_timeout();
        test_zero_delays();
        test_busy_noise();
        test_long_delays();
        test_random(0, 0, 100);
        test_random(46, 0, 100);
        test_random(0, 46, 100);
        test_random(13, 13, 100);

        hold_until_drained();
        repeat (4) @(posedge i_clk);
        if (bus_view_q.size() != 0) begin
            $error("%0d expected result beats never arrived", bus_view_q.size());
            fail_cnt++;
        end

        $display("ran %0d commands over %0d tick beats (%0d acknowledge timeouts)",
                 cmd_cnt, beat_cnt, tmo_cnt);
        $display("checked %0d result beats across %0d register settings and four mixes",
                 res_cnt, cfg_cnt);
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
